>>> rtl/gwps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwps_pkg
// shared types, codes and widths for the grid word path search block
// ----------------------------------------------------------------------------
package gwps_pkg;

	localparam int MAX_ROWS_DEF = 16;
	localparam int MAX_COLS_DEF = 16;
	localparam int MAX_WORD_DEF = 16;

	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int LIM_W     = 7;
	localparam int CHAR_W    = 8;
	localparam int POS_W     = 4;
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;

	localparam logic [1:0] ACT_GRID   = 2'd0;
	localparam logic [1:0] ACT_WORD   = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_START_CHK,
		ST_STEP,
		ST_POP,
		ST_CHK
	} seq_state_t;

	typedef struct packed {
		logic grid_we;
		logic word_we;
		logic vis_we;
		logic vis_wd;
	} store_ctl_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} res_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic logic [LIM_W-1:0] clamp_lim(input logic [CFG_W-1:0] v,
			input logic [LIM_W-1:0] hi);
		logic [LIM_W-1:0] w;
		w = LIM_W'(v);
		return (w > hi) ? hi : w;
	endfunction

endpackage
`default_nettype wire

>>> rtl/grid_word_path_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_word_path_search
// loads a character grid and a word, then searches for a 4-adjacent path
//
// channel  dir  signals                             words
// s_       in   s_tvalid s_tready s_tdata s_tuser   grid load, word load, search
// m_       out  m_tvalid m_tready m_tdata           one result per input word
// cfg_     in   cfg_we cfg_index cfg_wdata          row_count, col_count, word_length
//
// a load or an idle action is answered on the next edge
// a search tries start cells, directions that leave the grid, directions inside
// it and backtrack steps, paced by the single-port grid, word and visited
// memories that the walk reads once per step
// after reset all 2**(row bits + col bits) visited marks are swept
// (256 at 16 x 16), with s_tready low
// s_tready also stays low while a result waits on m_tready
// ----------------------------------------------------------------------------
module grid_word_path_search #(
	parameter int MAX_ROWS = gwps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gwps_pkg::MAX_COLS_DEF,
	parameter int MAX_WORD = gwps_pkg::MAX_WORD_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// cell_row, cell_col, char_value, word_pos, zero fill
	input  wire logic [gwps_pkg::S_TDATA_W-1:0]    s_tdata,
	// action
	input  wire logic [gwps_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// found, start_row, start_col, zero fill
	output logic      [gwps_pkg::M_TDATA_W-1:0]    m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [gwps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gwps_pkg::CFG_W-1:0]        cfg_wdata
);
	localparam int RW = gwps_pkg::idx_w(MAX_ROWS);
	localparam int CW = gwps_pkg::idx_w(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int WW = gwps_pkg::idx_w(MAX_WORD);
	localparam int EW = RW + CW + 3;

	logic [gwps_pkg::CFG_W-1:0] row_count_q, col_count_q, word_length_q;
	logic                       m_tvalid_q;
	logic [gwps_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                       out_free;

	gwps_pkg::store_ctl_t       ctl;
	gwps_pkg::res_t             res;
	logic [AW-1:0]              grid_addr, vis_addr;
	logic [WW-1:0]              word_addr, stk_waddr, stk_raddr;
	logic [gwps_pkg::CHAR_W-1:0] grid_q, word_q;
	logic                       vis_q, stk_we;
	logic [EW-1:0]              stk_wdata, stk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= gwps_pkg::CFG_W'(16);
			col_count_q   <= gwps_pkg::CFG_W'(16);
			word_length_q <= gwps_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				gwps_pkg::REG_ROW_COUNT:   row_count_q   <= cfg_wdata;
				gwps_pkg::REG_COL_COUNT:   col_count_q   <= cfg_wdata;
				gwps_pkg::REG_WORD_LENGTH: word_length_q <= cfg_wdata;
				default:                   row_count_q   <= row_count_q;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	gwps_seq #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_WORD (MAX_WORD)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.out_free    (out_free),
		.action      (s_tuser),
		.cell_row    (s_tdata[3:0]),
		.cell_col    (s_tdata[7:4]),
		.word_pos    (s_tdata[19:16]),
		.row_count   (row_count_q),
		.col_count   (col_count_q),
		.word_length (word_length_q),
		.ctl         (ctl),
		.grid_addr   (grid_addr),
		.word_addr   (word_addr),
		.vis_addr    (vis_addr),
		.grid_q      (grid_q),
		.word_q      (word_q),
		.vis_q       (vis_q),
		.stk_we      (stk_we),
		.stk_waddr   (stk_waddr),
		.stk_raddr   (stk_raddr),
		.stk_wdata   (stk_wdata),
		.stk_q       (stk_q),
		.res         (res)
	);

	gwps_store #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_WORD (MAX_WORD)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.grid_addr (grid_addr),
		.word_addr (word_addr),
		.vis_addr  (vis_addr),
		.wdata     (s_tdata[15:8]),
		.grid_q    (grid_q),
		.word_q    (word_q),
		.vis_q     (vis_q)
	);

	gwps_stack #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_WORD (MAX_WORD)
	) u_stack (
		.clk     (clk),
		.we      (stk_we),
		.waddr   (stk_waddr),
		.raddr   (stk_raddr),
		.wdata   (stk_wdata),
		.rdata_q (stk_q)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= gwps_pkg::M_TDATA_W'({res.col, res.row, res.found});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

>>> rtl/gwps_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwps_store
// grid, word and visited-mark memories, single port each, registered reads
// ----------------------------------------------------------------------------
module gwps_store #(
	parameter int MAX_ROWS = gwps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gwps_pkg::MAX_COLS_DEF,
	parameter int MAX_WORD = gwps_pkg::MAX_WORD_DEF,
	localparam int RW = gwps_pkg::idx_w(MAX_ROWS),
	localparam int CW = gwps_pkg::idx_w(MAX_COLS),
	localparam int AW = RW + CW,
	localparam int WW = gwps_pkg::idx_w(MAX_WORD)
) (
	input  wire logic                           clk,
	input  wire gwps_pkg::store_ctl_t           ctl,
	input  wire logic [AW-1:0]                  grid_addr,
	input  wire logic [WW-1:0]                  word_addr,
	input  wire logic [AW-1:0]                  vis_addr,
	input  wire logic [gwps_pkg::CHAR_W-1:0]    wdata,
	output logic      [gwps_pkg::CHAR_W-1:0]    grid_q,
	output logic      [gwps_pkg::CHAR_W-1:0]    word_q,
	output logic                                vis_q
);

	logic [gwps_pkg::CHAR_W-1:0] grid_mem [2**AW];
	logic [gwps_pkg::CHAR_W-1:0] word_mem [MAX_WORD];
	logic                        vis_mem  [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.grid_we) begin
			grid_mem[grid_addr] <= wdata;
		end
		grid_q <= grid_mem[grid_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.word_we) begin
			word_mem[word_addr] <= wdata;
		end
		word_q <= word_mem[word_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.vis_we) begin
			vis_mem[vis_addr] <= ctl.vis_wd;
		end
		vis_q <= vis_mem[vis_addr];
	end

endmodule
`default_nettype wire

>>> rtl/gwps_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwps_stack
// path stack below the top level: cell and next direction per level
// ----------------------------------------------------------------------------
module gwps_stack #(
	parameter int MAX_ROWS = gwps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gwps_pkg::MAX_COLS_DEF,
	parameter int MAX_WORD = gwps_pkg::MAX_WORD_DEF,
	localparam int RW = gwps_pkg::idx_w(MAX_ROWS),
	localparam int CW = gwps_pkg::idx_w(MAX_COLS),
	localparam int WW = gwps_pkg::idx_w(MAX_WORD),
	localparam int EW = RW + CW + 3
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [WW-1:0] waddr,
	input  wire logic [WW-1:0] raddr,
	input  wire logic [EW-1:0] wdata,
	output logic      [EW-1:0] rdata_q
);

	logic [EW-1:0] stk_mem [MAX_WORD];

	always_ff @(posedge clk) begin
		if (we) begin
			stk_mem[waddr] <= wdata;
		end
		rdata_q <= stk_mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/gwps_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwps_seq
// sequencer for loads and the depth-first walk, one memory step per state
// ----------------------------------------------------------------------------
module gwps_seq #(
	parameter int MAX_ROWS = gwps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gwps_pkg::MAX_COLS_DEF,
	parameter int MAX_WORD = gwps_pkg::MAX_WORD_DEF,
	localparam int RW = gwps_pkg::idx_w(MAX_ROWS),
	localparam int CW = gwps_pkg::idx_w(MAX_COLS),
	localparam int AW = RW + CW,
	localparam int WW = gwps_pkg::idx_w(MAX_WORD),
	localparam int EW = RW + CW + 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         out_free,
	input  wire logic [1:0]                   action,
	input  wire logic [gwps_pkg::POS_W-1:0]   cell_row,
	input  wire logic [gwps_pkg::POS_W-1:0]   cell_col,
	input  wire logic [gwps_pkg::POS_W-1:0]   word_pos,
	input  wire logic [gwps_pkg::CFG_W-1:0]   row_count,
	input  wire logic [gwps_pkg::CFG_W-1:0]   col_count,
	input  wire logic [gwps_pkg::CFG_W-1:0]   word_length,
	output gwps_pkg::store_ctl_t              ctl,
	output logic      [AW-1:0]                grid_addr,
	output logic      [WW-1:0]                word_addr,
	output logic      [AW-1:0]                vis_addr,
	input  wire logic [gwps_pkg::CHAR_W-1:0]  grid_q,
	input  wire logic [gwps_pkg::CHAR_W-1:0]  word_q,
	input  wire logic                         vis_q,
	output logic                              stk_we,
	output logic      [WW-1:0]                stk_waddr,
	output logic      [WW-1:0]                stk_raddr,
	output logic      [EW-1:0]                stk_wdata,
	input  wire logic [EW-1:0]                stk_q,
	output gwps_pkg::res_t                    res
);
	localparam int DW = $clog2(MAX_WORD + 1);
	localparam int LW = gwps_pkg::LIM_W;

	gwps_pkg::seq_state_t state_q, state_d;

	logic [AW-1:0] clr_addr_q;
	logic [RW-1:0] i_q, cur_r_q, cand_r_q, nb_r;
	logic [CW-1:0] j_q, cur_c_q, cand_c_q, nb_c;
	logic [2:0]    cur_dir_q;
	logic [DW-1:0] depth_q, depth_m1, depth_m2;
	logic          found_q;

	logic [LW-1:0] row_lim, col_lim, len_lim;
	logic          accept, zero_cfg, is_search;
	logic          scan_j_ok, scan_i_ok, scan_end;
	logic          pop, nb_ok, match, chk_ok, last_push, len_one, at_base;
	logic [AW-1:0] start_addr, cur_addr, nb_addr, cand_addr;

	assign row_lim = gwps_pkg::clamp_lim(row_count, LW'(MAX_ROWS));
	assign col_lim = gwps_pkg::clamp_lim(col_count, LW'(MAX_COLS));
	assign len_lim = gwps_pkg::clamp_lim(word_length, LW'(MAX_WORD));

	assign in_ready  = (state_q == gwps_pkg::ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign is_search = (action == gwps_pkg::ACT_SEARCH);
	assign zero_cfg  = (row_count == '0) || (col_count == '0) || (word_length == '0);

	assign scan_j_ok = (LW'(j_q) + LW'(1)) < col_lim;
	assign scan_i_ok = (LW'(i_q) + LW'(1)) < row_lim;
	assign scan_end  = !scan_j_ok && !scan_i_ok;

	assign start_addr = {i_q, j_q};
	assign cur_addr   = {cur_r_q, cur_c_q};
	assign cand_addr  = {cand_r_q, cand_c_q};
	assign nb_addr    = {nb_r, nb_c};

	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign pop       = cur_dir_q[2] || found_q;
	assign match     = (grid_q == word_q);
	assign chk_ok    = match && !vis_q;
	assign last_push = (LW'(depth_q) + LW'(1)) == len_lim;
	assign len_one   = (len_lim == LW'(1));
	assign at_base   = (depth_q == DW'(1));

	// neighbour in up, down, left, right order
	always_comb begin
		nb_r  = cur_r_q;
		nb_c  = cur_c_q;
		nb_ok = 1'b0;
		case (cur_dir_q[1:0])
			2'd0: begin
				nb_ok = (cur_r_q != '0);
				nb_r  = cur_r_q - RW'(1);
			end
			2'd1: begin
				nb_ok = (LW'(cur_r_q) + LW'(1)) < row_lim;
				nb_r  = cur_r_q + RW'(1);
			end
			2'd2: begin
				nb_ok = (cur_c_q != '0);
				nb_c  = cur_c_q - CW'(1);
			end
			default: begin
				nb_ok = (LW'(cur_c_q) + LW'(1)) < col_lim;
				nb_c  = cur_c_q + CW'(1);
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gwps_pkg::ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = gwps_pkg::ST_IDLE;
				end
			end
			gwps_pkg::ST_IDLE: begin
				if (accept && is_search && !zero_cfg) begin
					state_d = gwps_pkg::ST_SCAN;
				end
			end
			gwps_pkg::ST_SCAN: state_d = gwps_pkg::ST_START_CHK;
			gwps_pkg::ST_START_CHK: begin
				if (match) begin
					state_d = len_one ? gwps_pkg::ST_IDLE : gwps_pkg::ST_STEP;
				end else begin
					state_d = scan_end ? gwps_pkg::ST_IDLE : gwps_pkg::ST_SCAN;
				end
			end
			gwps_pkg::ST_STEP: begin
				if (pop) begin
					if (at_base) begin
						state_d = (found_q || scan_end) ? gwps_pkg::ST_IDLE
							: gwps_pkg::ST_SCAN;
					end else begin
						state_d = gwps_pkg::ST_POP;
					end
				end else if (nb_ok) begin
					state_d = gwps_pkg::ST_CHK;
				end
			end
			gwps_pkg::ST_POP: state_d = gwps_pkg::ST_STEP;
			gwps_pkg::ST_CHK: state_d = gwps_pkg::ST_STEP;
			default: state_d = gwps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		grid_addr = nb_addr;
		word_addr = depth_q[WW-1:0];
		vis_addr  = nb_addr;
		stk_we    = 1'b0;
		stk_waddr = depth_m1[WW-1:0];
		stk_raddr = depth_m2[WW-1:0];
		stk_wdata = {cur_r_q, cur_c_q, cur_dir_q};
		res       = '0;
		case (state_q)
			gwps_pkg::ST_CLEAR: begin
				vis_addr   = clr_addr_q;
				ctl.vis_we = 1'b1;
			end
			gwps_pkg::ST_IDLE: begin
				grid_addr   = {RW'(cell_row), CW'(cell_col)};
				word_addr   = WW'(word_pos);
				ctl.grid_we = accept && (action == gwps_pkg::ACT_GRID)
					&& (LW'(cell_row) < LW'(MAX_ROWS)) && (LW'(cell_col) < LW'(MAX_COLS));
				ctl.word_we = accept && (action == gwps_pkg::ACT_WORD)
					&& (LW'(word_pos) < LW'(MAX_WORD));
				res.valid   = accept && (!is_search || zero_cfg);
			end
			gwps_pkg::ST_SCAN: begin
				grid_addr = start_addr;
				word_addr = '0;
			end
			gwps_pkg::ST_START_CHK: begin
				vis_addr   = start_addr;
				ctl.vis_we = match && !len_one;
				ctl.vis_wd = 1'b1;
				res.valid  = (match && len_one) || (!match && scan_end);
				res.found  = match;
				res.row    = match ? gwps_pkg::POS_W'(i_q) : '0;
				res.col    = match ? gwps_pkg::POS_W'(j_q) : '0;
			end
			gwps_pkg::ST_STEP: begin
				if (pop) begin
					vis_addr   = cur_addr;
					ctl.vis_we = 1'b1;
					res.valid  = at_base && (found_q || scan_end);
					res.found  = found_q;
					res.row    = found_q ? gwps_pkg::POS_W'(i_q) : '0;
					res.col    = found_q ? gwps_pkg::POS_W'(j_q) : '0;
				end
			end
			gwps_pkg::ST_CHK: begin
				vis_addr   = cand_addr;
				ctl.vis_we = chk_ok;
				ctl.vis_wd = 1'b1;
				stk_we     = chk_ok;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gwps_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			depth_q    <= '0;
			found_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				gwps_pkg::ST_CLEAR: clr_addr_q <= clr_addr_q + AW'(1);
				gwps_pkg::ST_IDLE: begin
					found_q <= 1'b0;
					depth_q <= '0;
				end
				gwps_pkg::ST_START_CHK: begin
					if (match) begin
						depth_q <= DW'(1);
					end
				end
				gwps_pkg::ST_STEP: begin
					if (pop) begin
						depth_q <= depth_m1;
					end
				end
				gwps_pkg::ST_CHK: begin
					if (chk_ok) begin
						depth_q <= depth_q + DW'(1);
						if (last_push) begin
							found_q <= 1'b1;
						end
					end
				end
				default: begin
					depth_q <= depth_q;
				end
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		case (state_q)
			gwps_pkg::ST_IDLE: begin
				i_q <= '0;
				j_q <= '0;
			end
			gwps_pkg::ST_START_CHK: begin
				if (match) begin
					cur_r_q   <= i_q;
					cur_c_q   <= j_q;
					cur_dir_q <= '0;
				end else if (scan_j_ok) begin
					j_q <= j_q + CW'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + RW'(1);
				end
			end
			gwps_pkg::ST_STEP: begin
				if (pop) begin
					if (at_base && !found_q) begin
						if (scan_j_ok) begin
							j_q <= j_q + CW'(1);
						end else begin
							j_q <= '0;
							i_q <= i_q + RW'(1);
						end
					end
				end else begin
					cur_dir_q <= cur_dir_q + 3'd1;
					cand_r_q  <= nb_r;
					cand_c_q  <= nb_c;
				end
			end
			gwps_pkg::ST_POP: {cur_r_q, cur_c_q, cur_dir_q} <= stk_q;
			gwps_pkg::ST_CHK: begin
				if (chk_ok) begin
					cur_r_q   <= cand_r_q;
					cur_c_q   <= cand_c_q;
					cur_dir_q <= '0;
				end
			end
			default: begin
				cur_dir_q <= cur_dir_q;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/gwps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwps_checker
// port-level checks on the grid word path search block, bound to the top
// ----------------------------------------------------------------------------
module gwps_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [gwps_pkg::S_TUSER_W-1:0] s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [gwps_pkg::M_TDATA_W-1:0] m_tdata
);

	// no new word while a result is stuck
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while result stalled");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// loads answer on the next edge with nothing found
	a_load_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser != gwps_pkg::ACT_SEARCH))
		|=> (m_tvalid && !m_tdata[0]))
		else $error("load word not answered");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == '0))
		else $error("start cell set without a find");

	// a search either keeps the input closed or answers at once with no find
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == gwps_pkg::ACT_SEARCH))
		|=> ((!m_tvalid && !s_tready) || (m_tvalid && !m_tdata[0])))
		else $error("search finished too early");

endmodule

bind grid_word_path_search gwps_checker u_gwps_checker (.*);
`default_nettype wire
